// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cdatc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdatc_pkg
// Constants and register indexes for the CD audio track checksum block.
// ----------------------------------------------------------------------------
package cdatc_pkg;

   localparam int unsigned FRAME_W   = 32;
   localparam int unsigned SUM_W     = 32;
   localparam int unsigned TRACK_W   = 28;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [FRAME_W-1:0] LEAD_SKIP = 32'd2939;
   localparam logic [TRACK_W-1:0] TAIL_SKIP = 28'd2940;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_TRACK  = 2'd0,
      CSR_FINAL_TRACK  = 2'd1,
      CSR_TRACK_FRAMES = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/cd_audio_track_checksum_top.sv =====
// ----------------------------------------------------------------------------
// cd_audio_track_checksum_top
// The checksum word is registered after its end-of-track word passes stage 1 and stage 2.
// Throughput: one word per cycle; a held checksum stalls the next end word and all behind.
// Reset: synchronous, clears configuration registers, frame counter, sums and valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cd_audio_track_checksum_top
   import cdatc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // [31:0] sample_frame
   input  logic                    req_tlast,   // end_of_track
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // [31:0] checksum_v1, [63:32] checksum_v2
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [TRACK_W-1:0]      csr_wdata
);

   // configuration
   logic               first_track_ff, first_track_in;
   logic               final_track_ff, final_track_in;
   logic [TRACK_W-1:0] tail_start_ff, tail_start_in;

   // frame counter
   logic [FRAME_W-1:0] pos_ff, pos_in;

   // stage 1: frame, multiplier, skip
   logic               s1_valid_ff, s1_valid_in;
   logic [FRAME_W-1:0] s1_frame_ff, s1_frame_in;
   logic [FRAME_W-1:0] s1_mult_ff, s1_mult_in;
   logic               s1_skip_ff, s1_skip_in;
   logic               s1_last_ff, s1_last_in;

   // stage 2: product
   logic               s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]   s2_lo_ff, s2_lo_in;
   logic [SUM_W-1:0]   s2_hi_ff, s2_hi_in;
   logic               s2_last_ff, s2_last_in;

   // accumulators and output register
   logic [SUM_W-1:0]   sum1_ff, sum1_in;
   logic [SUM_W-1:0]   sum2_ff, sum2_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_v1_ff, rsp_v1_in;
   logic [SUM_W-1:0]   rsp_v2_ff, rsp_v2_in;

   logic               out_free, s2_go, s2_ready, s1_ready, req_go;
   logic [2*SUM_W-1:0] product;
   logic [SUM_W-1:0]   acc1, acc2;
   logic               skip_now;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_go      = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_ready   = !s2_valid_ff || s2_go;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_go     = req_tvalid && s1_ready;
   assign req_tready = s1_ready;

   assign skip_now = (first_track_ff && (pos_ff < LEAD_SKIP)) ||
                     (final_track_ff && (pos_ff >= {{(FRAME_W-TRACK_W){1'b0}}, tail_start_ff}));

   assign product = s1_frame_ff * s1_mult_ff;
   assign acc1    = sum1_ff + s2_lo_ff;
   assign acc2    = sum2_ff + s2_lo_ff + s2_hi_ff;

   always_comb begin
      first_track_in = first_track_ff;
      final_track_in = final_track_ff;
      tail_start_in  = tail_start_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_TRACK:  first_track_in = csr_wdata[0];
            CSR_FINAL_TRACK:  final_track_in = csr_wdata[0];
            CSR_TRACK_FRAMES: tail_start_in  = (csr_wdata >= TAIL_SKIP) ?
                                               (csr_wdata - TAIL_SKIP) : '0;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      s1_valid_in = s1_valid_ff;
      s1_frame_in = s1_frame_ff;
      s1_mult_in  = s1_mult_ff;
      s1_skip_in  = s1_skip_ff;
      s1_last_in  = s1_last_ff;
      if (s1_ready) begin
         s1_valid_in = req_tvalid;
         s1_frame_in = req_tdata;
         s1_mult_in  = pos_ff + 1'b1;
         s1_skip_in  = skip_now;
         s1_last_in  = req_tlast;
      end
      if (req_go) begin
         pos_in = req_tlast ? '0 : pos_ff + 1'b1;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_lo_in    = s2_lo_ff;
      s2_hi_in    = s2_hi_ff;
      s2_last_in  = s2_last_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_lo_in    = s1_skip_ff ? '0 : product[SUM_W-1:0];
         s2_hi_in    = s1_skip_ff ? '0 : product[2*SUM_W-1:SUM_W];
         s2_last_in  = s1_last_ff;
      end
   end

   always_comb begin
      sum1_in      = sum1_ff;
      sum2_in      = sum2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_v1_in    = rsp_v1_ff;
      rsp_v2_in    = rsp_v2_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_go) begin
         if (s2_last_ff) begin
            sum1_in      = '0;
            sum2_in      = '0;
            rsp_valid_in = 1'b1;
            rsp_v1_in    = acc1;
            rsp_v2_in    = acc2;
         end else begin
            sum1_in = acc1;
            sum2_in = acc2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_track_ff <= 1'b0;
         final_track_ff <= 1'b0;
         tail_start_ff  <= '0;
         pos_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         sum1_ff        <= '0;
         sum2_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_track_ff <= first_track_in;
         final_track_ff <= final_track_in;
         tail_start_ff  <= tail_start_in;
         pos_ff         <= pos_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         sum1_ff        <= sum1_in;
         sum2_ff        <= sum2_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_frame_ff <= s1_frame_in;
      s1_mult_ff  <= s1_mult_in;
      s1_skip_ff  <= s1_skip_in;
      s1_last_ff  <= s1_last_in;
      s2_lo_ff    <= s2_lo_in;
      s2_hi_ff    <= s2_hi_in;
      s2_last_ff  <= s2_last_in;
      rsp_v1_ff   <= rsp_v1_in;
      rsp_v2_ff   <= rsp_v2_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_v2_ff, rsp_v1_ff};

   `ASSERT_NEXT(a_pos_clear, clock, reset, req_go && req_tlast, pos_ff == '0, "frame counter not cleared at end of track")
   `ASSERT_NEXT(a_sum_clear, clock, reset, s2_go && s2_last_ff, (sum1_ff == '0) && (sum2_ff == '0), "sums not cleared after result")
   `ASSERT_NEXT(a_skip_zero, clock, reset, s1_valid_ff && s1_skip_ff && s2_ready, (s2_lo_ff == '0) && (s2_hi_ff == '0), "skipped frame added to sums")
   `ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(s2_valid_ff && s2_last_ff), "result without end-of-track word")

endmodule
